// ===== src/dpr_pkg.sv =====
// Shared types and constants for the Doppler rate ratio pipeline.
package dpr_pkg;

    localparam int unsigned SoundSpeed = 344;
    localparam logic [14:0] OneQ12 = 15'd4096;
    localparam logic [14:0] MinQ12 = 15'd1024;
    localparam logic [14:0] MaxQ12 = 15'd16384;
    localparam logic [15:0] ScaleReset = 16'd4096;
    localparam int SqrtSteps = 32;
    localparam int QuotBits = 29;

    typedef struct packed {
        logic signed [23:0] source_vel_x;
        logic signed [23:0] source_vel_y;
        logic signed [23:0] source_vel_z;
        logic signed [23:0] listener_vel_x;
        logic signed [23:0] listener_vel_y;
        logic signed [23:0] listener_vel_z;
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
    } in_item_t;

    typedef struct packed {
        logic [14:0] rate_ratio;
        logic        was_limited;
    } out_item_t;

    typedef struct packed {
        logic               zero;
        logic signed [49:0] dvs;
        logic signed [50:0] ndiff;
    } sq_side_t;

    typedef struct packed {
        logic zero;
        logic den_np;
        logic neg;
    } dv_side_t;

endpackage

// ===== src/dpr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module dpr_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [63:0]        in_x,
    input  dpr_pkg::sq_side_t  in_side,
    output logic               out_vld,
    output logic [31:0]        out_root,
    output dpr_pkg::sq_side_t  out_side
);

    localparam int N = dpr_pkg::SqrtSteps;

    logic [63:0]       x_reg   [N];
    logic [63:0]       res_reg [N];
    logic              vld_reg [N];
    dpr_pkg::sq_side_t side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [63:0]       x_cur;
        logic [63:0]       res_cur;
        logic              vld_cur;
        dpr_pkg::sq_side_t side_cur;
        logic [63:0]       trial;
        logic [63:0]       x_next;
        logic [63:0]       res_next;
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);

        if (k == 0) begin : g_first
            assign x_cur    = in_x;
            assign res_cur  = '0;
            assign vld_cur  = in_vld;
            assign side_cur = in_side;
        end
        else begin : g_rest
            assign x_cur    = x_reg[k-1];
            assign res_cur  = res_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        always_comb
        begin
            trial = res_cur + Bit;
            if (x_cur >= trial)
            begin
                x_next   = x_cur - trial;
                res_next = (res_cur >> 1) + Bit;
            end
            else
            begin
                x_next   = x_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = res_reg[N-1][31:0];
    assign out_side = side_reg[N-1];

endmodule

// ===== src/dpr_div.sv =====
// Pipelined restoring divider with overflow detect, one quotient bit per stage.
module dpr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [61:0]                  in_num,
    input  logic [50:0]                  in_den,
    input  dpr_pkg::dv_side_t            in_side,
    output logic                         out_vld,
    output logic [dpr_pkg::QuotBits-1:0] out_quot,
    output logic                         out_ovf,
    output logic                         out_rem_nz,
    output dpr_pkg::dv_side_t            out_side
);

    localparam int QB = dpr_pkg::QuotBits;
    localparam int NS = QB + 1;

    logic [51:0]       r_reg    [NS];
    logic [QB-1:0]     low_reg  [NS];
    logic [QB-1:0]     q_reg    [NS];
    logic [50:0]       d_reg    [NS];
    logic              ovf_reg  [NS];
    logic              vld_reg  [NS];
    dpr_pkg::dv_side_t side_reg [NS];

    // prep stage: upper dividend bits and overflow check
    logic [51:0] r0;
    assign r0 = {19'd0, in_num[61:QB]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= r0;
            low_reg[0]  <= in_num[QB-1:0];
            q_reg[0]    <= '0;
            d_reg[0]    <= in_den;
            ovf_reg[0]  <= (r0 >= {1'b0, in_den});
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
        localparam int B = QB - k;
        logic [51:0]   r_shift;
        logic [51:0]   r_next;
        logic [QB-1:0] q_next;

        always_comb
        begin
            r_shift = {r_reg[k-1][50:0], low_reg[k-1][B]};
            q_next  = q_reg[k-1];
            if (r_shift >= {1'b0, d_reg[k-1]})
            begin
                r_next    = r_shift - {1'b0, d_reg[k-1]};
                q_next[B] = 1'b1;
            end
            else
                r_next = r_shift;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= r_next;
                low_reg[k]  <= low_reg[k-1];
                q_reg[k]    <= q_next;
                d_reg[k]    <= d_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld    = vld_reg[NS-1];
    assign out_quot   = q_reg[NS-1];
    assign out_ovf    = ovf_reg[NS-1];
    assign out_rem_nz = (r_reg[NS-1] != '0);
    assign out_side   = side_reg[NS-1];

endmodule

// ===== src/doppler_ratio_calc.sv =====
// Doppler playback rate ratio: top level pipeline.
// Accepts one item per clock while the output is not stalled and returns one result per item,
// in order, through 68 register stages: two stages for the dot products, 32 square-root stages,
// one stage for the numerator and denominator, 30 divider stages, and three stages for
// deviation, scaling and clamping. A stall on the output holds the whole pipeline.
// doppler_scale is written over the cfg channel, which is always ready.
module doppler_ratio_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dpr_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dpr_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    logic        adv;
    logic [15:0] scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= dpr_pkg::ScaleReset;
        else if (cfg_valid)
            scale_reg <= cfg_data;
    end

    // stage 1: products
    logic               v1_reg;
    logic signed [47:0] pdd_reg [3];
    logic signed [47:0] pvs_reg [3];
    logic signed [47:0] pvl_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pdd_reg[0] <= in_data.offset_x * in_data.offset_x;
            pdd_reg[1] <= in_data.offset_y * in_data.offset_y;
            pdd_reg[2] <= in_data.offset_z * in_data.offset_z;
            pvs_reg[0] <= in_data.source_vel_x * in_data.offset_x;
            pvs_reg[1] <= in_data.source_vel_y * in_data.offset_y;
            pvs_reg[2] <= in_data.source_vel_z * in_data.offset_z;
            pvl_reg[0] <= in_data.listener_vel_x * in_data.offset_x;
            pvl_reg[1] <= in_data.listener_vel_y * in_data.offset_y;
            pvl_reg[2] <= in_data.listener_vel_z * in_data.offset_z;
        end
    end

    // stage 2: sums
    logic               v2_reg;
    logic [47:0]        len2_reg;
    dpr_pkg::sq_side_t  side2_reg;
    logic [47:0]        len2_next;
    logic signed [49:0] dvs_next;
    logic signed [49:0] dvl_next;

    always_comb
    begin
        len2_next = {1'b0, pdd_reg[0][46:0]} + {1'b0, pdd_reg[1][46:0]}
                  + {1'b0, pdd_reg[2][46:0]};
        dvs_next  = {{2{pvs_reg[0][47]}}, pvs_reg[0]} + {{2{pvs_reg[1][47]}}, pvs_reg[1]}
                  + {{2{pvs_reg[2][47]}}, pvs_reg[2]};
        dvl_next  = {{2{pvl_reg[0][47]}}, pvl_reg[0]} + {{2{pvl_reg[1][47]}}, pvl_reg[1]}
                  + {{2{pvl_reg[2][47]}}, pvl_reg[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len2_reg        <= len2_next;
            side2_reg.zero  <= (len2_next == '0);
            side2_reg.dvs   <= dvs_next;
            side2_reg.ndiff <= {dvl_next[49], dvl_next} - {dvs_next[49], dvs_next};
        end
    end

    // square root
    logic              vsq;
    logic [31:0]       len;
    dpr_pkg::sq_side_t sq_side;

    dpr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (v2_reg),
        .in_x     ({len2_reg, 16'd0}),
        .in_side  (side2_reg),
        .out_vld  (vsq),
        .out_root (len),
        .out_side (sq_side)
    );

    // stage 3: denominator and numerator magnitude
    logic               v3_reg;
    logic [61:0]        num3_reg;
    logic [50:0]        den3_reg;
    dpr_pkg::dv_side_t  side3_reg;
    logic [40:0]        base;
    logic signed [51:0] den_next;
    logic [50:0]        nmag;

    always_comb
    begin
        base     = 41'(len) * 41'(dpr_pkg::SoundSpeed);
        den_next = $signed({11'd0, base}) + {{2{sq_side.dvs[49]}}, sq_side.dvs};
        nmag     = sq_side.ndiff[50] ? 51'(-sq_side.ndiff) : 51'(sq_side.ndiff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= vsq;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num3_reg         <= {nmag[49:0], 12'd0};
            den3_reg         <= den_next[50:0];
            side3_reg.zero   <= sq_side.zero;
            side3_reg.den_np <= den_next[51] || (den_next == '0);
            side3_reg.neg    <= sq_side.ndiff[50];
        end
    end

    // divider
    logic                         vdv;
    logic [dpr_pkg::QuotBits-1:0] quot;
    logic                         ovf;
    logic                         rem_nz;
    dpr_pkg::dv_side_t            dv_side;

    dpr_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_vld     (v3_reg),
        .in_num     (num3_reg),
        .in_den     (den3_reg),
        .in_side    (side3_reg),
        .out_vld    (vdv),
        .out_quot   (quot),
        .out_ovf    (ovf),
        .out_rem_nz (rem_nz),
        .out_side   (dv_side)
    );

    // stage 4: signed floor deviation, saturated
    logic               v4_reg;
    logic signed [30:0] dev4_reg;
    dpr_pkg::dv_side_t  side4_reg;
    logic signed [30:0] dev_next;

    always_comb
    begin
        if (ovf)
            dev_next = dv_side.neg ? -(31'sd1 <<< 29) : (31'sd1 <<< 29);
        else if (dv_side.neg)
            dev_next = -$signed({2'b00, quot}) - $signed({30'd0, rem_nz});
        else
            dev_next = $signed({2'b00, quot});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= vdv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dev4_reg  <= dev_next;
            side4_reg <= dv_side;
        end
    end

    // stage 5: scale
    logic               v5_reg;
    logic signed [47:0] prod5_reg;
    dpr_pkg::dv_side_t  side5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod5_reg <= 48'(dev4_reg) * 48'($signed({1'b0, scale_reg}));
            side5_reg <= side4_reg;
        end
    end

    // stage 6: clamp into output register
    logic               out_valid_reg;
    dpr_pkg::out_item_t out_data_reg;
    dpr_pkg::out_item_t res_next;
    logic signed [36:0] ratio;

    always_comb
    begin
        ratio = 37'sd4096 + {prod5_reg[47], prod5_reg[47:12]};
        if (side5_reg.zero)
            res_next = '{rate_ratio: dpr_pkg::OneQ12, was_limited: 1'b0};
        else if (side5_reg.den_np)
            res_next = '{rate_ratio: dpr_pkg::MaxQ12, was_limited: 1'b1};
        else if (ratio < $signed({22'd0, dpr_pkg::MinQ12}))
            res_next = '{rate_ratio: dpr_pkg::MinQ12, was_limited: 1'b1};
        else if (ratio > $signed({22'd0, dpr_pkg::MaxQ12}))
            res_next = '{rate_ratio: dpr_pkg::MaxQ12, was_limited: 1'b1};
        else
            res_next = '{rate_ratio: ratio[14:0], was_limited: 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= res_next;
    end

    // advance whenever the output slot is free or being transferred
    assign adv       = ~out_valid_reg | out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/dpr_checker.sv =====
// Port-level assertions for the Doppler rate ratio block, with bind.
module dpr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dpr_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transfer dropped or changed while stalled");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.rate_ratio >= dpr_pkg::MinQ12
                   && out_data.rate_ratio <= dpr_pkg::MaxQ12)
        else $error("ratio out of range");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.was_limited |-> out_data.rate_ratio == dpr_pkg::MinQ12
                                          || out_data.rate_ratio == dpr_pkg::MaxQ12)
        else $error("limit flag without bound value");

endmodule

bind doppler_ratio_calc dpr_checker u_dpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
